// ===== src/frdf_pkg.sv =====
// ----------------------------------------------------------------------------
// frdf_pkg
// Shared types and constants for the flood relay duplicate filter.
// ----------------------------------------------------------------------------
package frdf_pkg;

  localparam int unsigned SEEN_DEPTH_DEFAULT = 16;
  localparam logic [7:0]  ALERT_LENGTH       = 8'd43;
  localparam int unsigned KEY_W              = 16;
  localparam int unsigned CFG_INDEX_W        = 2;
  localparam int unsigned CFG_DATA_W         = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ALERTS_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_LIMIT      = 2'd1;

  localparam logic       ALERTS_ENABLED_RESET = 1'b1;
  localparam logic [7:0] HOP_LIMIT_RESET      = 8'd3;

  typedef struct packed {
    logic [7:0] packet_length;
    logic [7:0] source_node;
    logic [7:0] sequence_number;
    logic [7:0] hop_count;
  } frdf_in_t;

  typedef struct packed {
    logic       accepted;
    logic       relay;
    logic [7:0] relay_hop_count;
    logic       duplicate;
  } frdf_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } frdf_cmd_t;

  typedef struct packed {
    logic need_search;
    logic last_idx;
    logic out_free;
  } frdf_stat_t;

endpackage

// ===== src/frdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// frdf_ctrl
// Sequencer: takes a request, walks the seen log if a search is needed, then hands off the result.
// ----------------------------------------------------------------------------
module frdf_ctrl
  import frdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  frdf_stat_t stat,
  output frdf_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.need_search ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/frdf_datapath.sv =====
// ----------------------------------------------------------------------------
// frdf_datapath
// Header checks, seen-key log with serial search, config and result register.
// ----------------------------------------------------------------------------
module frdf_datapath
  import frdf_pkg::*;
#(
  parameter int unsigned SEEN_DEPTH = SEEN_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  frdf_in_t               in_data,
  output frdf_out_t              out_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  frdf_cmd_t              cmd,
  output frdf_stat_t             stat
);

  localparam int unsigned IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SEEN_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(SEEN_DEPTH);

  logic             alerts_enabled;
  logic [7:0]       hop_limit;

  logic [KEY_W-1:0] seen_keys [SEEN_DEPTH];
  logic [IDX_W-1:0] write_slot;
  logic [CNT_W-1:0] fill_count;

  logic [KEY_W-1:0] key;
  logic [7:0]       hops;
  logic             accepted;
  logic             search;
  logic [IDX_W-1:0] scan_idx;
  logic [KEY_W-1:0] rd_data;
  logic             rd_live;
  logic             rd_pending;
  logic             hit;
  logic             store;
  logic [KEY_W-1:0] entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alerts_enabled <= ALERTS_ENABLED_RESET;
      hop_limit      <= HOP_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALERTS_ENABLED: alerts_enabled <= cfg_data[0];
        REG_HOP_LIMIT:      hop_limit      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // request capture and header checks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= {in_data.source_node, in_data.sequence_number};
      hops     <= in_data.hop_count;
      accepted <= alerts_enabled && (in_data.packet_length == ALERT_LENGTH)
                  && (in_data.hop_count != 8'd0);
      search   <= alerts_enabled && (in_data.packet_length == ALERT_LENGTH)
                  && (in_data.hop_count != 8'd0) && (in_data.hop_count < hop_limit);
    end
  end

  // serial search of the log, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= seen_keys[scan_idx];
      rd_live <= CNT_W'(scan_idx) < fill_count;
    end
  end

  assign entry = rd_live ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      hit        <= 1'b0;
      scan_idx   <= '0;
    end else begin
      rd_pending <= cmd.scan;
      if (cmd.load) begin
        hit      <= 1'b0;
        scan_idx <= '0;
      end else begin
        if (cmd.scan) begin
          scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
        end
        if (rd_pending && (entry == key)) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // log write for a new key
  assign store = cmd.finish && search && !hit;

  always_ff @(posedge clk) begin
    if (store) begin
      seen_keys[write_slot] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (store) begin
      write_slot <= (write_slot == LAST_IDX) ? '0 : write_slot + 1'b1;
      if (fill_count != FULL_CNT) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.accepted        <= accepted;
      out_data.relay           <= search && !hit;
      out_data.relay_hop_count <= (search && !hit)
                                  ? ((hops == 8'hff) ? 8'hff : hops + 8'd1) : 8'd0;
      out_data.duplicate       <= search && hit;
    end
  end

  assign stat.need_search = search;
  assign stat.last_idx    = (scan_idx == LAST_IDX);
  assign stat.out_free    = !out_valid || out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("log fill count beyond depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(write_slot) < FULL_CNT)
    else $error("write slot out of range");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_relay_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.relay) |-> (out_data.accepted && !out_data.duplicate))
    else $error("relay without acceptance or with duplicate");

  a_store_fill: assert property (@(posedge clk) disable iff (rst)
    (store && fill_count != FULL_CNT) |=> (fill_count == $past(fill_count) + 1'b1))
    else $error("fill count did not follow a log write");

endmodule

// ===== src/flood_relay_duplicate_filter_top.sv =====
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_top
// Mesh alert header filter: accept checks, duplicate search and relay hops.
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   in_data   (frdf_in_t)
// out      out  out_valid / out_ready out_data  (frdf_out_t)
// cfg      in   cfg_we                cfg_index, cfg_data
//
// a searched request goes from check through scan and drain to finish, one that
// needs no search from check to finish; the next request is taken in idle again
// the seen log has one read port, read one entry per cycle during the search
// a finished result waits in the output register; the next request is taken
// meanwhile, and a request only completes once that register is free
// synchronous reset clears the log (by fill count), write slot and config
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter_top
  import frdf_pkg::*;
#(
  parameter int unsigned SEEN_DEPTH = SEEN_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  frdf_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output frdf_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  frdf_cmd_t  cmd;
  frdf_stat_t stat;

  frdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frdf_datapath #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== dv/frdf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdf_checker
// Watches the config port and both handshake channels of the alert filter. It
// keeps its own seen log and register copies, works out the verdict of every
// request taken in and compares each returned verdict against the oldest one.
// ----------------------------------------------------------------------------
module frdf_checker
  import frdf_pkg::*;
#(
  parameter int unsigned SEEN_DEPTH = SEEN_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  frdf_in_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  frdf_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            fails,
  output int unsigned            outstanding,
  output int unsigned            relays,
  output int unsigned            duplicates
);

  logic             enabled;
  logic [7:0]       limit;
  logic [KEY_W-1:0] seen_log [SEEN_DEPTH];
  int unsigned      next_slot;
  frdf_out_t        expected_verdicts [$];

  function automatic frdf_out_t filter_alert(frdf_in_t pkt);
    frdf_out_t        v;
    logic [KEY_W-1:0] key;
    v = '0;
    key = {pkt.source_node, pkt.sequence_number};
    if (enabled && pkt.packet_length == ALERT_LENGTH && pkt.hop_count != 8'd0) begin
      v.accepted = 1'b1;
      if (pkt.hop_count < limit) begin
        for (int i = 0; i < SEEN_DEPTH; i++) begin
          if (seen_log[i] == key) v.duplicate = 1'b1;
        end
        if (!v.duplicate) begin
          v.relay = 1'b1;
          v.relay_hop_count = (pkt.hop_count == 8'hff) ? 8'hff : pkt.hop_count + 8'd1;
          seen_log[next_slot] = key;
          next_slot = (next_slot + 1) % SEEN_DEPTH;
        end
      end
    end
    return v;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    outstanding = 0;
    relays = 0;
    duplicates = 0;
  end

  always @(posedge clk) begin
    frdf_out_t want;
    if (rst) begin
      enabled = ALERTS_ENABLED_RESET;
      limit = HOP_LIMIT_RESET;
      foreach (seen_log[i]) seen_log[i] = '0;
      next_slot = 0;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ALERTS_ENABLED) enabled = cfg_data[0];
        else if (cfg_index == REG_HOP_LIMIT) limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict with no request pending, expected none, actual %h",
                   $time, out_data);
          fails++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(out_data.accepted));
          check_field("relay", 8'(want.relay), 8'(out_data.relay));
          check_field("relay_hop_count", want.relay_hop_count, out_data.relay_hop_count);
          check_field("duplicate", 8'(want.duplicate), 8'(out_data.duplicate));
        end
      end
      if (in_valid && in_ready) begin
        want = filter_alert(in_data);
        expected_verdicts.push_back(want);
        if (want.relay) relays++;
        if (want.duplicate) duplicates++;
      end
    end
    outstanding = expected_verdicts.size();
  end

endmodule

// ===== dv/flood_relay_duplicate_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_top_tb
// Drives alert headers into the filter under random stalls on both channels:
// a directed pass over drops, hop limit edges and the zero key left in the
// log by reset, then random traffic from a small key pool under several
// register settings. The checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter_top_tb;
  import frdf_pkg::*;

  localparam int unsigned RUN_LIMIT        = 1_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 220;
  localparam int unsigned SETTLE_CYCLES    = SEEN_DEPTH_DEFAULT + 12;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  frdf_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  frdf_out_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned fails;
  int unsigned outstanding;
  int unsigned relays;
  int unsigned duplicates;
  int unsigned cycles;
  int unsigned requests;
  int unsigned settings;
  bit          quiet;
  logic [7:0]  cur_limit;

  flood_relay_duplicate_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frdf_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding),
    .relays      (relays),
    .duplicates  (duplicates)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAIL flood_relay_duplicate_filter_top");
      $finish;
    end
  end

  task automatic send_alert(frdf_in_t pkt);
    int unsigned gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 37) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (in_ready !== 1'b1);
    requests++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_filter(logic en, logic [7:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= REG_ALERTS_ENABLED;
    cfg_data <= {7'd0, en};
    @(posedge clk);
    cfg_index <= REG_HOP_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = lim;
    settings++;
  endtask

  function automatic frdf_in_t rand_alert();
    frdf_in_t p;
    p.packet_length = ($urandom_range(99) < 85) ? ALERT_LENGTH : 8'($urandom);
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(3))
        0:       p.source_node = 8'h00;
        1:       p.source_node = 8'h01;
        2:       p.source_node = 8'h80;
        default: p.source_node = 8'hff;
      endcase
      p.sequence_number = 8'($urandom_range(7));
    end else begin
      p.source_node = 8'($urandom);
      p.sequence_number = 8'($urandom);
    end
    case ($urandom_range(9))
      0:          p.hop_count = 8'd0;
      1, 2:       p.hop_count = cur_limit;
      3, 4, 5, 6: p.hop_count = (cur_limit > 8'd1) ? 8'($urandom_range(1, cur_limit - 1))
                                                   : 8'd1;
      default:    p.hop_count = 8'($urandom);
    endcase
    return p;
  endfunction

  task automatic random_phase(logic en, logic [7:0] lim, bit calm);
    program_filter(en, lim);
    quiet = calm;
    repeat (RANDOM_PER_PHASE) send_alert(rand_alert());
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ALERTS_ENABLED;
    cfg_data = '0;
    cycles = 0;
    requests = 0;
    settings = 1;
    quiet = 1'b0;
    cur_limit = HOP_LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // key zero is already in the log after reset
    send_alert('{ALERT_LENGTH, 8'h00, 8'h00, 8'd1});
    send_alert('{8'd42, 8'h01, 8'h01, 8'd1});
    send_alert('{8'd44, 8'h01, 8'h01, 8'd1});
    send_alert('{8'd0, 8'h01, 8'h01, 8'd1});
    send_alert('{8'hff, 8'h01, 8'h01, 8'd1});
    send_alert('{ALERT_LENGTH, 8'h05, 8'h05, 8'd0});
    send_alert('{ALERT_LENGTH, 8'h05, 8'h05, 8'd3});
    send_alert('{ALERT_LENGTH, 8'h05, 8'h05, 8'hff});
    send_alert('{ALERT_LENGTH, 8'hff, 8'hff, 8'd2});
    send_alert('{ALERT_LENGTH, 8'hff, 8'hff, 8'd1});
    send_alert('{ALERT_LENGTH, 8'haa, 8'h55, 8'd1});
    // fill the ring so every zero entry is overwritten
    for (int i = 0; i < 14; i++) send_alert('{ALERT_LENGTH, 8'(8'h10 + i), 8'(i), 8'd2});
    send_alert('{ALERT_LENGTH, 8'h00, 8'h00, 8'd1});
    drain();
    program_filter(1'b0, HOP_LIMIT_RESET);
    send_alert('{ALERT_LENGTH, 8'h01, 8'h02, 8'd1});
    drain();
    program_filter(1'b1, 8'd0);
    send_alert('{ALERT_LENGTH, 8'h33, 8'h44, 8'd1});
    drain();

    random_phase(1'b1, 8'd3, 1'b0);
    random_phase(1'b1, 8'hff, 1'b1);
    random_phase(1'b1, 8'd1, 1'b0);
    random_phase(1'b0, 8'd200, 1'b0);
    random_phase(1'b1, 8'd0, 1'b0);
    random_phase(1'b1, 8'd8, 1'b0);
    random_phase(1'b1, 8'($urandom_range(2, 254)), 1'b0);
    random_phase(1'b1, 8'd3, 1'b0);

    $display("%0d alert requests over %0d register settings", requests, settings);
    $display("%0d relayed as new, %0d caught as duplicates", relays, duplicates);
    if (fails == 0 && outstanding == 0) begin
      $display("PASS flood_relay_duplicate_filter_top");
    end else begin
      $display("FAIL flood_relay_duplicate_filter_top");
    end
    $finish;
  end

endmodule
